[src/boscsi_pkg.sv]
package boscsi_pkg;

  localparam int BLOCK_BYTES  = 512;
  localparam int PACKET_BYTES = 64;

  localparam int PLEN_W      = 7;
  localparam int FILL_W      = $clog2(BLOCK_BYTES + 1);
  localparam int PKT_W       = $clog2(PACKET_BYTES + 1);
  localparam int TAKE_W0     = (FILL_W > PLEN_W) ? FILL_W : PLEN_W;
  localparam int TAKE_W      = (TAKE_W0 > PKT_W) ? TAKE_W0 : PKT_W;
  localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);

  localparam logic [FILL_W-1:0] BLOCK_FILL   = FILL_W'(BLOCK_BYTES);
  localparam logic [TAKE_W-1:0] BLOCK_TAKE   = TAKE_W'(BLOCK_BYTES);
  localparam logic [TAKE_W-1:0] PACKET_TAKE  = TAKE_W'(PACKET_BYTES);
  localparam logic [PLEN_W-1:0] WRAPPER_LEN  = 7'd31;

  localparam logic [31:0] CBW_SIGNATURE = 32'h4342_5355;

  localparam logic [7:0] OP_TEST_UNIT_READY  = 8'h00;
  localparam logic [7:0] OP_REQUEST_SENSE    = 8'h03;
  localparam logic [7:0] OP_INQUIRY          = 8'h12;
  localparam logic [7:0] OP_MODE_SENSE6      = 8'h1A;
  localparam logic [7:0] OP_PREVENT_REMOVAL  = 8'h1E;
  localparam logic [7:0] OP_READ_FORMAT_CAP  = 8'h23;
  localparam logic [7:0] OP_READ_CAPACITY    = 8'h25;
  localparam logic [7:0] OP_READ10           = 8'h28;
  localparam logic [7:0] OP_WRITE10          = 8'h2A;
  localparam logic [7:0] OP_VERIFY10         = 8'h2F;
  localparam logic [7:0] OP_MODE_SENSE10     = 8'h5A;

  localparam logic [7:0] INQUIRY_MIN_ALLOC = 8'd36;
  localparam logic [7:0] CB_LEN_SIX        = 8'd6;
  localparam logic [7:0] CB_LEN_TEN        = 8'd10;
  localparam logic [7:0] CB_LEN_MAX        = 8'd16;

  localparam logic [3:0] SK_NONE            = 4'h0;
  localparam logic [3:0] SK_MEDIUM_ERROR    = 4'h3;
  localparam logic [3:0] SK_ILLEGAL_REQUEST = 4'h5;
  localparam logic [7:0] ASC_NONE           = 8'h00;
  localparam logic [7:0] ASC_WRITE_FAULT    = 8'h03;
  localparam logic [7:0] ASC_READ_ERROR     = 8'h11;
  localparam logic [7:0] ASC_INVALID_OPCODE = 8'h20;
  localparam logic [7:0] ASC_INVALID_FIELD  = 8'h24;

  localparam logic CFG_DISK_BYTES    = 1'b0;
  localparam logic CFG_WRITE_PROTECT = 1'b1;

  typedef enum logic [1:0] {
    CMD_PACKET     = 2'd0,
    CMD_READ_DONE  = 2'd1,
    CMD_WRITE_DONE = 2'd2,
    CMD_RESET      = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    KIND_INQUIRY     = 4'd0,
    KIND_SENSE       = 4'd1,
    KIND_CAPACITY    = 4'd2,
    KIND_FORMAT_CAP  = 4'd3,
    KIND_MODE6       = 4'd4,
    KIND_MODE10      = 4'd5,
    KIND_STATUS      = 4'd6,
    KIND_READ_REQ    = 4'd7,
    KIND_WRITE_REQ   = 4'd8
  } kind_e;

  typedef enum logic [1:0] {
    ST_PASSED      = 2'd0,
    ST_FAILED      = 2'd1,
    ST_PHASE_ERROR = 2'd2
  } status_e;

  typedef struct packed {
    logic [3:0]  kind;
    logic [1:0]  status;
    logic [31:0] reply_tag;
    logic [31:0] last_lba;
    logic [31:0] block_addr;
    logic [15:0] block_count;
    logic [3:0]  sense_key;
    logic [7:0]  sense_code;
    logic        protected_flag;
    logic        last;
  } result_t;

endpackage

[src/bulk_only_scsi_command_engine.sv]
// A result is written into the result queue when its input transaction is taken.
// One input transaction is taken per cycle while the queue holds two results or
// fewer; results leave the four-entry result queue at one result per cycle while
// out_stall_i is low. Commands that answer with data and a status push two results.
// Reset is asynchronous and active low and clears the configuration, the sense
// data, the write data phase and the result queue.
module bulk_only_scsi_command_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [6:0]  packet_len_i,
  input  logic [31:0] signature_i,
  input  logic [31:0] tag_i,
  input  logic [7:0]  cb_length_i,
  input  logic [7:0]  opcode_i,
  input  logic [7:0]  cdb_byte_four_i,
  input  logic [31:0] lba_i,
  input  logic [15:0] xfer_blocks_i,
  input  logic        flash_ok_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  kind_o,
  output logic [1:0]  status_o,
  output logic [31:0] reply_tag_o,
  output logic [31:0] last_lba_o,
  output logic [31:0] block_addr_o,
  output logic [15:0] block_count_o,
  output logic [3:0]  sense_key_out_o,
  output logic [7:0]  sense_code_out_o,
  output logic        protected_flag_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import boscsi_pkg::*;

  logic [31:0] disk_bytes_q;
  logic        write_protect_q;
  logic        room;
  logic        accept;
  result_t     res0, res1, head;
  logic [1:0]  res_count;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !room;
  assign accept      = in_valid_i && room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disk_bytes_q    <= '0;
      write_protect_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DISK_BYTES:    disk_bytes_q    <= cfg_data_i;
        CFG_WRITE_PROTECT: write_protect_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  boscsi_engine u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .cmd_i           (cmd_i),
    .packet_len_i    (packet_len_i),
    .signature_i     (signature_i),
    .tag_i           (tag_i),
    .cb_length_i     (cb_length_i),
    .opcode_i        (opcode_i),
    .cdb_byte_four_i (cdb_byte_four_i),
    .lba_i           (lba_i),
    .xfer_blocks_i   (xfer_blocks_i),
    .flash_ok_i      (flash_ok_i),
    .disk_bytes_i    (disk_bytes_q),
    .write_protect_i (write_protect_q),
    .res0_o          (res0),
    .res1_o          (res1),
    .res_count_o     (res_count)
  );

  boscsi_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (accept),
    .push_count_i (res_count),
    .push0_i      (res0),
    .push1_i      (res1),
    .room_o       (room),
    .valid_o      (out_valid_o),
    .pop_i        (!out_stall_i),
    .head_o       (head)
  );

  assign kind_o           = head.kind;
  assign status_o         = head.status;
  assign reply_tag_o      = head.reply_tag;
  assign last_lba_o       = head.last_lba;
  assign block_addr_o     = head.block_addr;
  assign block_count_o    = head.block_count;
  assign sense_key_out_o  = head.sense_key;
  assign sense_code_out_o = head.sense_code;
  assign protected_flag_o = head.protected_flag;
  assign last_o           = head.last;

endmodule

[src/boscsi_engine.sv]
module boscsi_engine (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  logic [1:0]               cmd_i,
  input  logic [6:0]               packet_len_i,
  input  logic [31:0]              signature_i,
  input  logic [31:0]              tag_i,
  input  logic [7:0]               cb_length_i,
  input  logic [7:0]               opcode_i,
  input  logic [7:0]               cdb_byte_four_i,
  input  logic [31:0]              lba_i,
  input  logic [15:0]              xfer_blocks_i,
  input  logic                     flash_ok_i,
  input  logic [31:0]              disk_bytes_i,
  input  logic                     write_protect_i,
  output boscsi_pkg::result_t      res0_o,
  output boscsi_pkg::result_t      res1_o,
  output logic [1:0]               res_count_o
);
  import boscsi_pkg::*;

  logic [3:0]        sense_key_q, sense_key_d;
  logic [7:0]        sense_code_q, sense_code_d;
  logic              recv_q, recv_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [31:0]       next_block_q, next_block_d;
  logic [15:0]       remaining_q, remaining_d;
  logic [31:0]       saved_tag_q, saved_tag_d;
  logic              failed_q, failed_d;

  logic [31:0]       last_lba;
  logic              six, ten, bad_wrapper;
  logic [TAKE_W-1:0] room, take;
  logic [TAKE_W:0]   fill_sum;
  logic [15:0]       remaining_dec;
  result_t           r0, r1;
  logic [1:0]        n;

  function automatic result_t make_status(logic [1:0] st, logic [31:0] tg);
    result_t r;
    r = '0;
    r.kind = KIND_STATUS;
    r.status = st;
    r.reply_tag = tg;
    return r;
  endfunction

  assign last_lba    = (disk_bytes_i >> BLOCK_SHIFT) - 32'd1;
  assign six         = cb_length_i >= CB_LEN_SIX;
  assign ten         = cb_length_i >= CB_LEN_TEN;
  assign bad_wrapper = (signature_i != CBW_SIGNATURE) || (cb_length_i == 8'd0) ||
                       (cb_length_i > CB_LEN_MAX);
  assign room        = BLOCK_TAKE - TAKE_W'(fill_q);
  assign remaining_dec = (remaining_q != 16'd0) ? remaining_q - 16'd1 : remaining_q;

  always_comb begin
    take = TAKE_W'(packet_len_i);
    if (take > PACKET_TAKE) begin
      take = PACKET_TAKE;
    end
    if (take > room) begin
      take = room;
    end
    fill_sum = {1'b0, TAKE_W'(fill_q)} + {1'b0, take};
  end

  always_comb begin
    sense_key_d  = sense_key_q;
    sense_code_d = sense_code_q;
    recv_d       = recv_q;
    fill_d       = fill_q;
    next_block_d = next_block_q;
    remaining_d  = remaining_q;
    saved_tag_d  = saved_tag_q;
    failed_d     = failed_q;
    r0 = '0;
    r1 = '0;
    n  = 2'd0;
    case (cmd_i)
      CMD_PACKET: begin
        if (recv_q) begin
          if (fill_q < BLOCK_FILL && take != '0) begin
            fill_d = FILL_W'(fill_sum);
            if (FILL_W'(fill_sum) == BLOCK_FILL) begin
              r0.kind        = KIND_WRITE_REQ;
              r0.block_addr  = next_block_q;
              r0.block_count = remaining_q;
              n = 2'd1;
            end
          end
        end else if (packet_len_i == WRAPPER_LEN) begin
          if (bad_wrapper) begin
            r0 = make_status(ST_PHASE_ERROR, tag_i);
            n = 2'd1;
          end else if (opcode_i == OP_INQUIRY && six) begin
            if (cdb_byte_four_i >= INQUIRY_MIN_ALLOC) begin
              r0.kind = KIND_INQUIRY;
              r1 = make_status(ST_PASSED, tag_i);
              n = 2'd2;
            end else begin
              sense_key_d  = SK_ILLEGAL_REQUEST;
              sense_code_d = ASC_INVALID_FIELD;
              r0 = make_status(ST_FAILED, tag_i);
              n = 2'd1;
            end
          end else if (opcode_i == OP_TEST_UNIT_READY && six) begin
            r0 = make_status(ST_PASSED, tag_i);
            n = 2'd1;
          end else if (opcode_i == OP_REQUEST_SENSE && six) begin
            r0.kind       = KIND_SENSE;
            r0.sense_key  = sense_key_q;
            r0.sense_code = sense_code_q;
            sense_key_d   = SK_NONE;
            sense_code_d  = ASC_NONE;
            r1 = make_status(ST_PASSED, tag_i);
            n = 2'd2;
          end else if ((opcode_i == OP_READ_CAPACITY || opcode_i == OP_READ_FORMAT_CAP)
                       && six) begin
            r0.kind     = (opcode_i == OP_READ_CAPACITY) ? KIND_CAPACITY : KIND_FORMAT_CAP;
            r0.last_lba = last_lba;
            r1 = make_status(ST_PASSED, tag_i);
            n = 2'd2;
          end else if ((opcode_i == OP_MODE_SENSE6 || opcode_i == OP_MODE_SENSE10) && six) begin
            r0.kind           = (opcode_i == OP_MODE_SENSE6) ? KIND_MODE6 : KIND_MODE10;
            r0.protected_flag = write_protect_i;
            r1 = make_status(ST_PASSED, tag_i);
            n = 2'd2;
          end else if (opcode_i == OP_PREVENT_REMOVAL && six) begin
            if (cdb_byte_four_i[0]) begin
              sense_key_d  = SK_ILLEGAL_REQUEST;
              sense_code_d = ASC_INVALID_FIELD;
              r0 = make_status(ST_FAILED, tag_i);
            end else begin
              r0 = make_status(ST_PASSED, tag_i);
            end
            n = 2'd1;
          end else if (opcode_i == OP_READ10 && ten) begin
            saved_tag_d    = tag_i;
            r0.kind        = KIND_READ_REQ;
            r0.block_addr  = lba_i;
            r0.block_count = xfer_blocks_i;
            n = 2'd1;
          end else if (opcode_i == OP_WRITE10 && ten) begin
            saved_tag_d = tag_i;
            if (xfer_blocks_i == 16'd0) begin
              r0 = make_status(ST_PASSED, tag_i);
              n = 2'd1;
            end else begin
              recv_d       = 1'b1;
              fill_d       = '0;
              next_block_d = lba_i;
              remaining_d  = xfer_blocks_i;
            end
          end else if (opcode_i == OP_VERIFY10 && ten) begin
            r0 = make_status(ST_PASSED, tag_i);
            n = 2'd1;
          end else begin
            sense_key_d  = SK_ILLEGAL_REQUEST;
            sense_code_d = ASC_INVALID_OPCODE;
            r0 = make_status(ST_FAILED, tag_i);
            n = 2'd1;
          end
        end
      end
      CMD_READ_DONE: begin
        if (!flash_ok_i) begin
          sense_key_d  = SK_MEDIUM_ERROR;
          sense_code_d = ASC_READ_ERROR;
          r0 = make_status(ST_FAILED, saved_tag_q);
        end else begin
          r0 = make_status(ST_PASSED, saved_tag_q);
        end
        n = 2'd1;
      end
      CMD_WRITE_DONE: begin
        if (recv_q && fill_q == BLOCK_FILL) begin
          if (!flash_ok_i) begin
            failed_d     = 1'b1;
            sense_key_d  = SK_MEDIUM_ERROR;
            sense_code_d = ASC_WRITE_FAULT;
          end
          fill_d       = '0;
          next_block_d = next_block_q + 32'd1;
          remaining_d  = remaining_dec;
          if (remaining_dec == 16'd0) begin
            recv_d   = 1'b0;
            failed_d = 1'b0;
            r0 = make_status((failed_q || !flash_ok_i) ? ST_FAILED : ST_PASSED,
                             saved_tag_q);
            n = 2'd1;
          end
        end
      end
      CMD_RESET: begin
        sense_key_d  = SK_NONE;
        sense_code_d = ASC_NONE;
        recv_d       = 1'b0;
        fill_d       = '0;
        failed_d     = 1'b0;
      end
      default: begin
      end
    endcase
    if (n == 2'd1) begin
      r0.last = 1'b1;
    end
    if (n == 2'd2) begin
      r1.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sense_key_q  <= '0;
      sense_code_q <= '0;
      recv_q       <= 1'b0;
      fill_q       <= '0;
      next_block_q <= '0;
      remaining_q  <= '0;
      saved_tag_q  <= '0;
      failed_q     <= 1'b0;
    end else if (accept_i) begin
      sense_key_q  <= sense_key_d;
      sense_code_q <= sense_code_d;
      recv_q       <= recv_d;
      fill_q       <= fill_d;
      next_block_q <= next_block_d;
      remaining_q  <= remaining_d;
      saved_tag_q  <= saved_tag_d;
      failed_q     <= failed_d;
    end
  end

  assign res0_o      = r0;
  assign res1_o      = r1;
  assign res_count_o = n;

endmodule

[src/boscsi_queue.sv]
module boscsi_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [1:0]          push_count_i,
  input  boscsi_pkg::result_t push0_i,
  input  boscsi_pkg::result_t push1_i,
  output logic                room_o,
  output logic                valid_o,
  input  logic                pop_i,
  output boscsi_pkg::result_t head_o
);
  import boscsi_pkg::*;

  result_t    entries_q [4];
  logic [1:0] wr_ptr_q, wr_ptr_d;
  logic [1:0] rd_ptr_q, rd_ptr_d;
  logic [2:0] count_q, count_d;
  logic [1:0] n_in;
  logic       do_pop;

  assign n_in    = push_i ? push_count_i : 2'd0;
  assign do_pop  = pop_i && (count_q != 3'd0);
  assign wr_ptr_d = wr_ptr_q + n_in;
  assign rd_ptr_d = rd_ptr_q + {1'b0, do_pop};
  assign count_d  = count_q + {1'b0, n_in} - {2'b00, do_pop};

  // Two free entries are needed so that any transaction can be taken.
  assign room_o  = count_q <= 3'd2;
  assign valid_o = count_q != 3'd0;
  assign head_o  = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (n_in != 2'd0) begin
      entries_q[wr_ptr_q] <= push0_i;
    end
    if (n_in == 2'd2) begin
      entries_q[wr_ptr_q + 2'd1] <= push1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule
